>>> hdl/tknr_pkg.sv
package tknr_pkg;

    // Number of cells in the sorted chain.
    localparam int CAPACITY = 16;

    // A squared planar distance of two 17-bit differences fits in 34 bits.
    localparam int DIST_W = 34;
    localparam int SQ_W   = DIST_W - 1;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_FLUSH  = 1'b1;

    localparam logic CFG_CENTER_X = 1'b0;
    localparam logic CFG_CENTER_Y = 1'b1;

    typedef struct packed {
        logic               opcode;
        logic [15:0]        ordinal;
        logic [7:0]         rank;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic [31:0]        payload;
    } cmd_t;

    typedef struct packed {
        logic [15:0]        out_ordinal;
        logic [7:0]         out_rank;
        logic signed [15:0] out_x;
        logic signed [15:0] out_y;
        logic [31:0]        out_payload;
        logic [3:0]         slot_index;
        logic               is_empty;
        logic               last;
    } result_t;

    typedef struct packed {
        logic [15:0]        ordinal;
        logic [7:0]         rank;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [31:0]        payload;
    } entry_t;

    typedef struct packed {
        logic insert;
        logic shift_up;
    } cell_ctrl_t;

    // True when item a strictly comes before item b in the list order.
    function automatic logic precedes(
        input logic [7:0]        rank_a,
        input logic [DIST_W-1:0] dist_a,
        input logic [15:0]       ord_a,
        input logic [7:0]        rank_b,
        input logic [DIST_W-1:0] dist_b,
        input logic [15:0]       ord_b
    );
        logic result;
        if (rank_a != rank_b)
        begin
            result = (rank_a > rank_b);
        end
        else if (dist_a != dist_b)
        begin
            result = (dist_a < dist_b);
        end
        else
        begin
            result = (ord_a < ord_b);
        end
        return result;
    endfunction

endpackage

>>> hdl/top_k_nearest_rank_selector.sv
// Channel   Signals                          Transfer
// -------   -------------------------------  ---------------------------------
// request   start, busy, cmd (cmd_t)         start high while busy is low
// result    result_valid, result (result_t)  back to back, no stall
// config    cfg_we, cfg_index, cfg_data      every cycle cfg_we is high
//
// An insert request keeps busy high through ST_SQ, ST_SUM and ST_INS after
// it is accepted: ST_SQ and ST_SUM compute the new item's squared distance,
// and in ST_INS every cell of the chain compares against it and the run of
// cells it beats, counted back from the tail, shifts down by one place in one
// step. A flush request keeps busy high until every stored entry is given out
// (one result for an empty list), each in the cycle after its flush cycle.
// Reset empties the list and clears the center; no clearing pass is needed.
// The receiver cannot stall, so results are never held back.
module top_k_nearest_rank_selector
    import tknr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  cmd_t        cmd,
    output logic        result_valid,
    output result_t     result,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQ,
        ST_SUM,
        ST_INS,
        ST_FLUSH
    } state_t;

    state_t             state_reg;
    logic               result_valid_reg;
    result_t            result_reg;
    logic [3:0]         slot_reg;

    logic signed [15:0] center_x_reg;
    logic signed [15:0] center_y_reg;
    entry_t             item_reg;
    logic [DIST_W-1:0]  item_dist;
    logic               accept;
    logic               head_next_valid;
    cell_ctrl_t         ctrl;

    entry_t             cell_entry [CAPACITY];
    logic               cell_valid [CAPACITY];
    logic               cell_take  [CAPACITY];

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;

    // The center registers take a write in the cycle it is offered.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg <= '0;
            center_y_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_CENTER_X: center_x_reg <= cfg_data;
                CFG_CENTER_Y: center_y_reg <= cfg_data;
                default:      center_x_reg <= center_x_reg;
            endcase
        end
    end

    // The accepted item is held while its distance is worked out.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.ordinal <= cmd.ordinal;
            item_reg.rank    <= cmd.rank;
            item_reg.x       <= cmd.pos_x;
            item_reg.y       <= cmd.pos_y;
            item_reg.payload <= cmd.payload;
        end
    end

    tknr_dist u_item_dist (
        .clk     (clk),
        .x       (item_reg.x),
        .y       (item_reg.y),
        .cx      (center_x_reg),
        .cy      (center_y_reg),
        .dist_sq (item_dist)
    );

    assign ctrl.insert   = (state_reg == ST_INS);
    assign ctrl.shift_up = (state_reg == ST_FLUSH);

    // Cell zero is the best entry. Each cell sees its upper neighbor for
    // inserts and its lower neighbor for flushes. The tail always lets the
    // new item start its climb.
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        entry_t prev_entry;
        logic   prev_valid;
        logic   prev_take;
        entry_t next_entry;
        logic   next_valid;
        logic   next_take;

        if (i == 0)
        begin : g_head
            assign prev_entry = item_reg;
            assign prev_valid = 1'b0;
            assign prev_take  = 1'b0;
        end
        else
        begin : g_body
            assign prev_entry = cell_entry[i-1];
            assign prev_valid = cell_valid[i-1];
            assign prev_take  = cell_take[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_tail
            assign next_entry = item_reg;
            assign next_valid = 1'b0;
            assign next_take  = 1'b1;
        end
        else
        begin : g_inner
            assign next_entry = cell_entry[i+1];
            assign next_valid = cell_valid[i+1];
            assign next_take  = cell_take[i+1];
        end

        tknr_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .new_entry  (item_reg),
            .new_dist   (item_dist),
            .cx         (center_x_reg),
            .cy         (center_y_reg),
            .prev_entry (prev_entry),
            .prev_valid (prev_valid),
            .prev_take  (prev_take),
            .next_entry (next_entry),
            .next_valid (next_valid),
            .next_take  (next_take),
            .entry      (cell_entry[i]),
            .valid      (cell_valid[i]),
            .take       (cell_take[i])
        );
    end

    // The entry behind the head tells whether the head is the final result.
    if (CAPACITY > 1)
    begin : g_next_head
        assign head_next_valid = cell_valid[1];
    end
    else
    begin : g_single
        assign head_next_valid = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            result_valid_reg <= 1'b0;
            result_reg       <= '0;
            slot_reg         <= '0;
        end
        else
        begin
            result_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        slot_reg <= '0;
                        if (cmd.opcode == OP_FLUSH)
                        begin
                            state_reg <= ST_FLUSH;
                        end
                        else
                        begin
                            state_reg <= ST_SQ;
                        end
                    end
                end
                ST_SQ:
                begin
                    state_reg <= ST_SUM;
                end
                ST_SUM:
                begin
                    state_reg <= ST_INS;
                end
                ST_INS:
                begin
                    state_reg <= ST_IDLE;
                end
                ST_FLUSH:
                begin
                    result_valid_reg <= 1'b1;
                    if (!cell_valid[0])
                    begin
                        // An empty list gives a single zeroed result.
                        result_reg <= '{is_empty: 1'b1, last: 1'b1, default: '0};
                        state_reg  <= ST_IDLE;
                    end
                    else
                    begin
                        result_reg.out_ordinal <= cell_entry[0].ordinal;
                        result_reg.out_rank    <= cell_entry[0].rank;
                        result_reg.out_x       <= cell_entry[0].x;
                        result_reg.out_y       <= cell_entry[0].y;
                        result_reg.out_payload <= cell_entry[0].payload;
                        result_reg.slot_index  <= slot_reg;
                        result_reg.is_empty    <= 1'b0;
                        result_reg.last        <= !head_next_valid;
                        slot_reg               <= slot_reg + 4'd1;
                        if (!head_next_valid)
                        begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

>>> hdl/tknr_dist.sv
// Two-stage squared distance: squares registered, then their sum registered.
module tknr_dist
    import tknr_pkg::*;
(
    input  logic                clk,
    input  logic signed [15:0]  x,
    input  logic signed [15:0]  y,
    input  logic signed [15:0]  cx,
    input  logic signed [15:0]  cy,
    output logic [DIST_W-1:0]   dist_sq
);

    logic signed [16:0]     dx;
    logic signed [16:0]     dy;
    logic signed [33:0]     sqx_full;
    logic signed [33:0]     sqy_full;
    logic [SQ_W-1:0]        sqx_reg;
    logic [SQ_W-1:0]        sqy_reg;
    logic [DIST_W-1:0]      dist_reg;

    assign dx       = 17'(x) - 17'(cx);
    assign dy       = 17'(y) - 17'(cy);
    assign sqx_full = dx * dx;
    assign sqy_full = dy * dy;

    always_ff @(posedge clk)
    begin
        sqx_reg  <= sqx_full[SQ_W-1:0];
        sqy_reg  <= sqy_full[SQ_W-1:0];
        dist_reg <= {1'b0, sqx_reg} + {1'b0, sqy_reg};
    end

    assign dist_sq = dist_reg;

endmodule

>>> hdl/tknr_cell.sv
// One slot of the sorted chain. On an insert the cell keeps its entry, takes
// the new item, or takes its upper neighbor's entry; on a flush it takes its
// lower neighbor's entry.
module tknr_cell
    import tknr_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  cell_ctrl_t          ctrl,
    input  entry_t              new_entry,
    input  logic [DIST_W-1:0]   new_dist,
    input  logic signed [15:0]  cx,
    input  logic signed [15:0]  cy,
    input  entry_t              prev_entry,
    input  logic                prev_valid,
    input  logic                prev_take,
    input  entry_t              next_entry,
    input  logic                next_valid,
    input  logic                next_take,
    output entry_t              entry,
    output logic                valid,
    output logic                take
);

    entry_t             entry_reg;
    entry_t             entry_next;
    logic               valid_reg;
    logic               valid_next;
    logic [DIST_W-1:0]  entry_dist;
    logic               beats;

    tknr_dist u_dist (
        .clk     (clk),
        .x       (entry_reg.x),
        .y       (entry_reg.y),
        .cx      (cx),
        .cy      (cy),
        .dist_sq (entry_dist)
    );

    // An empty cell always accepts. The new item climbs from the tail only
    // while it beats every entry below, so this cell joins the moving run
    // only when the cell below it does too.
    assign beats = !valid_reg ||
                   precedes(new_entry.rank, new_dist, new_entry.ordinal,
                            entry_reg.rank, entry_dist, entry_reg.ordinal);
    assign take  = beats && next_take;

    always_comb
    begin
        entry_next = entry_reg;
        valid_next = valid_reg;
        if (ctrl.insert && take)
        begin
            if (prev_take)
            begin
                entry_next = prev_entry;
                valid_next = prev_valid;
            end
            else
            begin
                entry_next = new_entry;
                valid_next = 1'b1;
            end
        end
        else if (ctrl.shift_up)
        begin
            entry_next = next_entry;
            valid_next = next_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;
    assign valid = valid_reg;

endmodule

>>> hdl/tknr_checker.sv
module tknr_checker
    import tknr_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        result_valid,
    input result_t     result
);

    // An accepted request always raises busy in the cycle after it is accepted.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted request did not raise busy");

    // An empty flush is always a single, zeroed result.
    a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.is_empty |->
            result.last && result.slot_index == 4'd0 && result.out_payload == 32'd0)
        else $error("empty flush result malformed");

    // Flush results come back to back until the final one.
    a_burst: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.last |=> result_valid && !result.is_empty)
        else $error("flush burst broken before its last result");

    // Slot positions count up by one within a flush.
    a_slot_step: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.last |=>
            result.slot_index == 4'($past(result.slot_index) + 4'd1))
        else $error("slot index did not advance by one");

endmodule

bind top_k_nearest_rank_selector tknr_checker u_tknr_checker (.*);
